@@ hdl/crc32_crc64_byte_engine_top_assert.svh @@
// Assertion macros for the CRC byte engine.
// Both forms sample on the rising edge of i_clk and are ignored while reset is asserted.
`ifndef CRC32_CRC64_BYTE_ENGINE_TOP_ASSERT_SVH
`define CRC32_CRC64_BYTE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CRCBE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crcbe assertion failed");

`define CRCBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crcbe assertion failed");

`else

`define CRCBE_ASSERT_SAME(lbl, ante, cons)

`define CRCBE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hdl/crcbe_pkg.sv @@
package crcbe_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned CRC_W   = 64;
    localparam int unsigned CRC32_W = 32;
    localparam int unsigned CFG_W   = 1;

    localparam logic [CRC32_W-1:0] POLY32 = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]   POLY64 = 64'hD800_0000_0000_0000;

    // Configuration register indexes
    localparam logic CFG_IDX_WIDTH_MODE  = 1'b0;
    localparam logic CFG_IDX_SWAP_RESULT = 1'b1;

    // 32-bit path: eight LSB-first shift steps, unrolled into an XOR network
    function automatic logic [CRC32_W-1:0] fold32(input logic [CRC32_W-1:0] x);
        logic [CRC32_W-1:0] v;
        v = x;
        for (int k = 0; k < DATA_W; k++) begin
            v = v[0] ? ((v >> 1) ^ POLY32) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] fold64(input logic [CRC_W-1:0] x);
        logic [CRC_W-1:0] v;
        v = x;
        for (int k = 0; k < DATA_W; k++) begin
            v = v[0] ? ((v >> 1) ^ POLY64) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] swap64(input logic [CRC_W-1:0] x);
        logic [CRC_W-1:0] v;
        for (int k = 0; k < CRC_W / 8; k++) begin
            v[8*k +: 8] = x[CRC_W - 8 - 8*k +: 8];
        end
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] swap32(input logic [CRC_W-1:0] x);
        logic [CRC_W-1:0] v;
        v = '0;
        for (int k = 0; k < CRC32_W / 8; k++) begin
            v[8*k +: 8] = x[CRC32_W - 8 - 8*k +: 8];
        end
        return v;
    endfunction

endpackage

@@ hdl/crcbe_in_if.sv @@
interface crcbe_in_if;
    import crcbe_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

@@ hdl/crcbe_out_if.sv @@
interface crcbe_out_if;
    import crcbe_pkg::*;

    logic             valid;
    logic             ready;
    logic [CRC_W-1:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface

@@ hdl/crc32_crc64_byte_engine_top.sv @@
// A result appears on o_out in the cycle after the item marked last is accepted.
// One byte per cycle unless stalled; the CRC is folded in an 8-step XOR network per width.
// The input stalls only while a finished result waits in the output register unread.
// Reset (i_rst_n low, synchronous): running CRC cleared, output empty,
// width_mode = 0 (32-bit), swap_result = 1.
`include "crc32_crc64_byte_engine_top_assert.svh"

module crc32_crc64_byte_engine_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic                      i_cfg_index,
    input  logic [crcbe_pkg::CFG_W-1:0] i_cfg_wdata,
    crcbe_in_if.sink                  i_in,
    crcbe_out_if.source               o_out
);
    import crcbe_pkg::*;

    logic             r_width_mode;
    logic             r_swap_result;
    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic             r_out_valid;
    logic [CRC_W-1:0] r_out_crc;
    logic [CRC_W-1:0] n_out_crc;
    logic [CRC_W-1:0] fold_in;
    logic             in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign fold_in = r_crc ^ {{(CRC_W-DATA_W){1'b0}}, i_in.data_byte};

    always_comb begin
        if (r_width_mode) begin
            n_crc = fold64(fold_in);
        end else begin
            n_crc = {{(CRC_W-CRC32_W){1'b0}}, fold32(fold_in[CRC32_W-1:0])};
        end
        if (!r_swap_result) begin
            n_out_crc = n_crc;
        end else if (r_width_mode) begin
            n_out_crc = swap64(n_crc);
        end else begin
            n_out_crc = swap32(n_crc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode  <= 1'b0;
            r_swap_result <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH_MODE:  r_width_mode  <= i_cfg_wdata[0];
                CFG_IDX_SWAP_RESULT: r_swap_result <= i_cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                // the last byte closes the buffer: hand off the CRC and start over
                r_crc <= i_in.last ? '0 : n_crc;
                if (i_in.last) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last) begin
            r_out_crc <= n_out_crc;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.crc_value = r_out_crc;

    `CRCBE_ASSERT_NEXT(a_last_gives_result, in_acc && i_in.last, o_out.valid)
    `CRCBE_ASSERT_NEXT(a_last_clears_crc, in_acc && i_in.last, r_crc == '0)
    `CRCBE_ASSERT_SAME(a_stall_only_when_full, !i_in.ready, r_out_valid && !o_out.ready)
    `CRCBE_ASSERT_NEXT(a_narrow_upper_zero, in_acc && !r_width_mode,
        r_crc[CRC_W-1:CRC32_W] == '0)

endmodule

@@ test/tb_crc32_crc64_byte_engine_top.sv @@
`timescale 1ns / 100ps

typedef enum logic {
    MODE_CRC32 = 1'b0,
    MODE_CRC64 = 1'b1
} crc_mode_e;

// Tracks the running CRC per byte and holds the CRCs still owed by the block.
class crc_predictor;
    localparam logic [63:0] CRC32_POLY = 64'h0000_0000_04C1_1DB7;
    localparam logic [63:0] CRC64_POLY = 64'hD800_0000_0000_0000;

    logic [63:0] running;
    crc_mode_e   mode;
    logic        swap_en;
    logic [63:0] pending_crcs[$];
    int          mismatch_cnt;

    function new();
        running      = '0;
        mode         = MODE_CRC32;
        swap_en      = 1'b1;
        mismatch_cnt = 0;
    endfunction

    function void set_reg(input logic idx, input logic [crcbe_pkg::CFG_W-1:0] val);
        if (idx == crcbe_pkg::CFG_IDX_WIDTH_MODE) begin
            mode = crc_mode_e'(val[0]);
        end else begin
            swap_en = val[0];
        end
    endfunction

    function void note_byte(input logic [7:0] data, input logic is_last);
        logic [63:0] poly;
        logic [63:0] acc;
        logic [63:0] crc;
        int          nbytes;
        if (mode == MODE_CRC64) begin
            poly   = CRC64_POLY;
            acc    = running ^ {56'd0, data};
            nbytes = 8;
        end else begin
            // 32-bit step only sees the low word; upper word drops to zero
            poly   = CRC32_POLY;
            acc    = {32'd0, running[31:0] ^ {24'd0, data}};
            nbytes = 4;
        end
        for (int k = 0; k < 8; k++) begin
            acc = (acc >> 1) ^ (acc[0] ? poly : 64'd0);
        end
        running = acc;
        if (is_last) begin
            crc = '0;
            if (swap_en) begin
                for (int k = 0; k < nbytes; k++) begin
                    crc[8*(nbytes-1-k) +: 8] = acc[8*k +: 8];
                end
            end else begin
                crc = acc;
            end
            pending_crcs.push_back(crc);
            running = '0;
        end
    endfunction

    function void check_crc(input logic [63:0] actual);
        logic [63:0] exp_crc;
        if (pending_crcs.size() == 0) begin
            $display("%0t: unexpected CRC, expected none, actual %h", $time, actual);
            mismatch_cnt++;
        end else begin
            exp_crc = pending_crcs.pop_front();
            if (actual !== exp_crc) begin
                $display("%0t: CRC mismatch, expected %h, actual %h", $time, exp_crc, actual);
                mismatch_cnt++;
            end
        end
    endfunction

    function int outstanding();
        return pending_crcs.size();
    endfunction
endclass

module tb_crc32_crc64_byte_engine_top;
    import crcbe_pkg::*;

    localparam int   CYCLE_LIMIT    = 200000;
    localparam int   PHASE_ITEMS    = 230;
    localparam int   NUM_PHASES     = 8;
    localparam logic SWAP_OFF       = 1'b0;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic             i_cfg_index;
    logic [CFG_W-1:0] i_cfg_wdata;

    int send_idle_pct;
    int recv_stall_pct;
    int cycle_cnt;

    crc_predictor tracker = new();

    crcbe_in_if  in_if();
    crcbe_out_if out_if();

    crc32_crc64_byte_engine_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check on accept, then draw ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_crc(out_if.crc_value);
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_item(input logic [DATA_W-1:0] data, input logic is_last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_if.valid     <= 1'b0;
            in_if.data_byte <= DATA_W'($urandom);
            in_if.last      <= 1'($urandom);
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= data;
        in_if.last      <= is_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        tracker.note_byte(data, is_last);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        wait_drained();
        // a buffer may be open with no result owed; let its last byte settle
        repeat (3) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return DATA_W'($urandom);
    endfunction

    initial begin
        int sent;
        int buf_len;
        int r;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_IDX_WIDTH_MODE;
        i_cfg_wdata     = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last      = 1'b0;
        out_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: 32-bit, swapped; zero, all-ones and single-bit bytes
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'hA5, 1'b1);
        // switch to 64-bit in the middle of a buffer
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);
        write_reg(CFG_IDX_WIDTH_MODE, MODE_CRC64);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        write_reg(CFG_IDX_SWAP_RESULT, SWAP_OFF);
        send_item(8'h80, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h7F, 1'b1);
        // back to 32-bit mid-buffer: upper word of the running CRC is dropped
        send_item(8'h12, 1'b0);
        send_item(8'hC3, 1'b0);
        write_reg(CFG_IDX_WIDTH_MODE, MODE_CRC32);
        send_item(8'h34, 1'b1);
        send_item(8'h01, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_IDX_WIDTH_MODE, crc_mode_e'(ph[0]));
            write_reg(CFG_IDX_SWAP_RESULT, ph[1] ^ ph[2]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 50) buf_len = $urandom_range(4, 1);
                else if (r < 90) buf_len = $urandom_range(24, 5);
                else buf_len = $urandom_range(80, 25);
                // a buffer cut short here carries over into the next setting
                for (int i = 0; i < buf_len && sent < PHASE_ITEMS; i++) begin
                    send_item(pick_byte(), i == buf_len - 1);
                    sent++;
                end
                if ($urandom_range(49) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.outstanding() != 0) begin
            $display("%0t: %0d CRCs never arrived", $time, tracker.outstanding());
        end
        if (tracker.mismatch_cnt == 0 && tracker.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/crcbe_pkg.sv
hdl/crcbe_in_if.sv
hdl/crcbe_out_if.sv
hdl/crc32_crc64_byte_engine_top.sv
test/tb_crc32_crc64_byte_engine_top.sv
